// ----- rtl/core/chyp_pkg.sv -----
// Shared constants and the CORDIC gain function for the hypotenuse pipeline.
// No dependencies.
`default_nettype none

package chyp_pkg;

   localparam int GAIN_FRAC = 24;

   // floor(2^24 * prod_{i=0..last_shift+1} 1/sqrt(1+4^-i)), evaluated at elaboration
   function automatic logic [GAIN_FRAC-1:0] gain_q24(input int last_shift);
      logic [63:0]          p;
      logic [GAIN_FRAC-1:0] g;
      logic [GAIN_FRAC-1:0] t;
      logic [111:0]         prod;
      int                   i;
      int                   b;
      p = 64'd1 << 60;
      g = '0;
      for (i = 0; i <= last_shift + 1; i++) begin
         if (2 * i < 64) begin
            p = p + (p >> (2 * i));
         end
      end
      for (b = GAIN_FRAC - 1; b >= 0; b--) begin
         t    = g | (GAIN_FRAC'(1) << b);
         prod = 112'(t) * 112'(t) * 112'(p);
         if (prod <= (112'd1 << 108)) begin
            g = t;
         end
      end
      return g;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/chyp_rot_stage.sv -----
// One registered vectoring CORDIC micro-rotation with a valid/ready handshake.
// No package dependencies.
`default_nettype none

module chyp_rot_stage #(
   parameter int XW    = 21,
   parameter int SHIFT = 0
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic signed [XW-1:0] in_x,
   input  wire logic signed [XW-1:0] in_y,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic signed [XW-1:0]      out_x,
   output logic signed [XW-1:0]      out_y
);

   logic                 valid_ff;
   logic signed [XW-1:0] x_ff;
   logic signed [XW-1:0] y_ff;
   logic signed [XW-1:0] x_in;
   logic signed [XW-1:0] y_in;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;

   assign xs = in_x >>> SHIFT;
   assign ys = in_y >>> SHIFT;

   always_comb begin
      if (!in_y[XW-1]) begin
         x_in = in_x + ys;
         y_in = in_y - xs;
      end else begin
         x_in = in_x - ys;
         y_in = in_y + xs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/cordic_hypotenuse.sv -----
// Pipelined CORDIC hypotenuse: rounded sqrt(side_a^2 + side_b^2).
// Depends on chyp_pkg and chyp_rot_stage.
//
// The block accepts one item per clock while req_tready is high and returns
// one length per item, in order. One stage orders the legs, LAST_SHIFT+1
// stages each apply one micro-rotation, one stage forms two partial products
// with the gain constant and the output stage sums them and rounds. Every
// stage holds its item under back-pressure and empty stages close up, so the
// input keeps taking items while a result waits, until every stage is full.
`default_nettype none

module cordic_hypotenuse #(
   parameter int INPUT_BITS    = 12,
   parameter int LAST_SHIFT    = 12,
   parameter int FRACTION_BITS = 6
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // side_a [INPUT_BITS-1:0], side_b [2*INPUT_BITS-1:INPUT_BITS], zero fill
   input  wire logic [((2*INPUT_BITS+7)/8)*8-1:0]    req_tdata,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // length [INPUT_BITS:0], zero fill
   output logic [((INPUT_BITS+1+7)/8)*8-1:0]         rsp_tdata
);

   localparam int GF    = chyp_pkg::GAIN_FRAC;
   localparam int XW    = INPUT_BITS + FRACTION_BITS + 3;
   localparam int UX    = XW - 1;
   localparam int H     = (UX + 1) / 2;
   localparam int HW    = UX - H;
   localparam int PLW   = H + GF;
   localparam int PHW   = HW + GF;
   localparam int PW    = UX + GF;
   localparam int LW    = INPUT_BITS + 1;
   localparam int RSPW  = ((INPUT_BITS + 1 + 7) / 8) * 8;
   localparam int NST   = LAST_SHIFT + 1;
   localparam logic [GF-1:0] GAIN = chyp_pkg::gain_q24(LAST_SHIFT);
   localparam logic [UX:0]   RND  = (UX+1)'((1 << (FRACTION_BITS - 1)) + 1);

   logic [INPUT_BITS-1:0] side_a;
   logic [INPUT_BITS-1:0] side_b;
   logic                  rdy0;
   logic                  v0_ff;
   logic signed [XW-1:0]  x0_ff;
   logic signed [XW-1:0]  y0_ff;
   logic [INPUT_BITS-1:0] big;
   logic [INPUT_BITS-1:0] sml;

   logic                  vs [NST+1];
   logic                  rs [NST+1];
   logic signed [XW-1:0]  xs [NST+1];
   logic signed [XW-1:0]  ys [NST+1];

   logic                  rdym1;
   logic                  vm1_ff;
   logic [PLW-1:0]        plo_ff;
   logic [PHW-1:0]        phi_ff;
   logic [PLW-1:0]        plo_in;
   logic [PHW-1:0]        phi_in;
   logic [UX-1:0]         xu;

   logic                  rdyo;
   logic                  vo_ff;
   logic [LW-1:0]         len_ff;
   logic [PW-1:0]         prod;
   logic [UX:0]           sum;
   logic [LW-1:0]         len_in;

   assign side_a = req_tdata[INPUT_BITS-1:0];
   assign side_b = req_tdata[2*INPUT_BITS-1:INPUT_BITS];

   // order the legs: larger one becomes x
   assign big = (side_a < side_b) ? side_b : side_a;
   assign sml = (side_a < side_b) ? side_a : side_b;

   assign rdy0       = !v0_ff || rs[0];
   assign req_tready = rdy0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (rdy0) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy0 && req_tvalid) begin
         x0_ff <= XW'({big, FRACTION_BITS'(0)});
         y0_ff <= XW'({sml, FRACTION_BITS'(0)});
      end
   end

   assign vs[0] = v0_ff;
   assign xs[0] = x0_ff;
   assign ys[0] = y0_ff;

   for (genvar k = 0; k < NST; k++) begin : g_rot
      chyp_rot_stage #(
         .XW    (XW),
         .SHIFT (k)
      ) u_rot (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vs[k]),
         .in_ready  (rs[k]),
         .in_x      (xs[k]),
         .in_y      (ys[k]),
         .out_valid (vs[k+1]),
         .out_ready (rs[k+1]),
         .out_x     (xs[k+1]),
         .out_y     (ys[k+1])
      );
   end

   assign rs[NST] = rdym1;

   // split the gain multiply into two narrow partial products
   assign xu     = xs[NST][UX-1:0];
   assign plo_in = PLW'(xu[H-1:0]) * PLW'(GAIN);
   assign phi_in = PHW'(xu[UX-1:H]) * PHW'(GAIN);
   assign rdym1  = !vm1_ff || rdyo;

   always_ff @(posedge clock) begin
      if (reset) begin
         vm1_ff <= 1'b0;
      end else if (rdym1) begin
         vm1_ff <= vs[NST];
      end
   end

   always_ff @(posedge clock) begin
      if (rdym1 && vs[NST]) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
   end

   assign prod   = (PW'(phi_ff) << H) + PW'(plo_ff);
   assign sum    = (UX+1)'(prod[PW-1:GF]) + RND;
   assign len_in = sum[FRACTION_BITS +: LW];
   assign rdyo   = !vo_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (rdyo) begin
         vo_ff <= vm1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdyo && vm1_ff) begin
         len_ff <= len_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = RSPW'(len_ff);

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v0_ff)
      else $error("input stalled with empty first stage");

   a_last_rot_hold : assert property (@(posedge clock) disable iff (reset)
      vs[NST] && !rdym1 |=> vs[NST])
      else $error("rotation item dropped under stall");

   a_x_nonneg : assert property (@(posedge clock) disable iff (reset)
      vs[NST] |-> !xs[NST][XW-1])
      else $error("rotated x went negative");

endmodule

`default_nettype wire
